FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the masked mean block.
// Needs nothing else; define SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/mmd_pkg.sv
// Types, constants and width helpers of the masked mean and deviation block.
// Used by every module of the block; depends on nothing.
package mmd_pkg;
	localparam int DEF_MAX_FRAMES = 65536;
	localparam int VAL_W = 18;
	localparam int DEV_W = 17;
	localparam int NOUT_W = 17;
	localparam int QUO_W = 38;
	localparam int ROOT_W = QUO_W / 2;
	localparam logic signed [VAL_W-1:0] MARKER_RST = -18'sd51200;
	localparam logic [DEV_W-1:0] DEV_MAX = '1;

	typedef struct packed {
		logic signed [VAL_W-1:0] sample_value;
		logic last_sample;
	} in_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] mean_value;
		logic mean_valid;
		logic [DEV_W-1:0] deviation_value;
		logic deviation_valid;
		logic [NOUT_W-1:0] counted_frames;
	} out_t;

	typedef enum logic [3:0] {
		S_ACCUM, S_DRAIN, S_MEAN, S_NS2, S_S1S1, S_DEN, S_VAR, S_SQRT, S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_DIV_MEAN, OP_MUL_NS2, OP_MUL_S1S1, OP_MUL_DEN, OP_DIV_VAR, OP_SQRT
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
		logic load_out;
	} arith_cmd_t;

	typedef struct packed {
		logic last_seen;
		logic pipe_empty;
		logic n_ge1;
		logic n_ge2;
	} acc_stat_t;

	function automatic int cnt_width(input int max_frames);
		return $clog2(max_frames + 1);
	endfunction
endpackage

FILE: hw/rtl/masked_mean_and_deviation.sv
// Top level of the masked mean and deviation block.
// Depends on mmd_pkg, mmd_accum, mmd_arith, mmd_ctrl and assert_macros.svh.
//
// Input beats carry one Q10.8 dB frame value and a last-frame flag. They are
// taken one per cycle while a window is open. Values equal to the marker
// register are skipped, and values past MAX_FRAMES counted frames are dropped.
// The beat flagged last closes the window: the input then stalls while the sums
// drain and the window-end sequence runs on one shared shift-add multiplier,
// one restoring divider and one square root unit. An empty window skips the
// arithmetic, and a window with one counted frame computes only the mean.
// The result beat sits in an output register; the next window accumulates
// while it waits, and only the next window end waits on a stalled receiver.
// The marker register is written by cfg_write/cfg_data; the user must write
// it only while idle, as the block itself does not enforce this.
// Reset clears the sums, sets the marker to -200 dB and empties the output.
`include "assert_macros.svh"

module masked_mean_and_deviation #(
	parameter int MAX_FRAMES = mmd_pkg::DEF_MAX_FRAMES
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic signed [mmd_pkg::VAL_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input mmd_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output mmd_pkg::out_t out_data
);
	import mmd_pkg::*;

	localparam int CW = cnt_width(MAX_FRAMES);
	localparam int SW = VAL_W + CW;
	localparam int QSW = 2 * (VAL_W - 1) + CW;

	acc_stat_t acc_stat;
	arith_cmd_t cmd;
	logic clr, done;
	logic [CW-1:0] count;
	logic signed [SW-1:0] sum;
	logic [QSW-1:0] sq;

	mmd_accum #(.MAX_FRAMES(MAX_FRAMES)) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.clear(clr),
		.stat(acc_stat),
		.count(count),
		.sum(sum),
		.sq(sq)
	);

	mmd_arith #(.MAX_FRAMES(MAX_FRAMES)) u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.count(count),
		.sum(sum),
		.sq(sq),
		.done(done),
		.out_data(out_data)
	);

	mmd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(acc_stat),
		.done(done),
		.out_stall(out_stall),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.clear(clr),
		.cmd(cmd)
	);

	`ASSERT_IMPLY(a_load_free, clk, arst_n, cmd.load_out, !out_valid || !out_stall)
	`ASSERT_IMPLY(a_start_stalled, clk, arst_n, cmd.start, in_stall)
	`ASSERT_IMPLY(a_clear_drained, clk, arst_n, clr, acc_stat.pipe_empty && in_stall)
	`ASSERT_ALWAYS(a_dev_needs_mean, clk, arst_n, !out_valid || !out_data.deviation_valid || out_data.mean_valid)
endmodule

FILE: hw/rtl/mmd_accum.sv
// Input side of the block: marker register, square pipeline and window sums.
// Depends on mmd_pkg.
module mmd_accum #(
	parameter int MAX_FRAMES = mmd_pkg::DEF_MAX_FRAMES,
	localparam int CW = mmd_pkg::cnt_width(MAX_FRAMES),
	localparam int SW = mmd_pkg::VAL_W + CW,
	localparam int QSW = 2 * (mmd_pkg::VAL_W - 1) + CW
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic signed [mmd_pkg::VAL_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input mmd_pkg::in_t in_data,
	input logic clear,
	output mmd_pkg::acc_stat_t stat,
	output logic [CW-1:0] count,
	output logic signed [SW-1:0] sum,
	output logic [QSW-1:0] sq
);
	import mmd_pkg::*;

	localparam int SQ1W = 2 * VAL_W - 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAMES);

	logic signed [VAL_W-1:0] marker_q;
	logic [CW-1:0] count_q;
	logic signed [SW-1:0] sum_q;
	logic [QSW-1:0] sq_q;
	logic add_s1, add_s2;
	logic signed [VAL_W-1:0] value_s1, value_s2;
	logic [SQ1W-1:0] square_s2;
	logic signed [2*VAL_W-1:0] prod;
	logic accept, keep;

	assign accept = in_valid && !in_stall;
	assign keep = accept && (in_data.sample_value != marker_q) && (count_q < MAX_C);
	assign prod = value_s1 * value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RST;
			count_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			add_s1 <= 1'b0;
			add_s2 <= 1'b0;
		end else begin
			if (cfg_write) begin
				marker_q <= cfg_data;
			end
			add_s1 <= keep;
			add_s2 <= add_s1;
			if (clear) begin
				count_q <= '0;
				sum_q <= '0;
				sq_q <= '0;
			end else begin
				if (keep) begin
					count_q <= count_q + CW'(1);
				end
				if (add_s2) begin
					sum_q <= sum_q + SW'(value_s2);
					sq_q <= sq_q + QSW'(square_s2);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		value_s1 <= in_data.sample_value;
		value_s2 <= value_s1;
		square_s2 <= prod[SQ1W-1:0];
	end

	always_comb begin
		stat.last_seen = accept && in_data.last_sample;
		stat.pipe_empty = !add_s1 && !add_s2;
		stat.n_ge1 = count_q != '0;
		stat.n_ge2 = count_q > CW'(1);
	end

	assign count = count_q;
	assign sum = sum_q;
	assign sq = sq_q;
endmodule

FILE: hw/rtl/mmd_arith.sv
// Window-end arithmetic: shift-add multiplier, restoring divider, square root
// and the result register. Depends on mmd_pkg.
module mmd_arith #(
	parameter int MAX_FRAMES = mmd_pkg::DEF_MAX_FRAMES,
	localparam int CW = mmd_pkg::cnt_width(MAX_FRAMES),
	localparam int SW = mmd_pkg::VAL_W + CW,
	localparam int QSW = 2 * (mmd_pkg::VAL_W - 1) + CW
) (
	input logic clk,
	input logic arst_n,
	input mmd_pkg::arith_cmd_t cmd,
	input logic [CW-1:0] count,
	input logic signed [SW-1:0] sum,
	input logic [QSW-1:0] sq,
	output logic done,
	output mmd_pkg::out_t out_data
);
	import mmd_pkg::*;

	localparam int MW = SW - 1;
	localparam int PW = QSW + CW;
	localparam int AW = QSW;
	localparam int BW = MW;
	localparam int PMW = AW + BW;
	localparam int VW = 2 * CW;
	localparam int DDW = PW + 2;
	localparam int STEPS_MAX = (BW > QUO_W) ? BW : QUO_W;
	localparam int CNTW = $clog2(STEPS_MAX + 1);

	logic busy_q, done_q;
	op_t op_q;
	logic [CNTW-1:0] cnt_q;

	logic [AW-1:0] a_q;
	logic [PMW-1:0] p_q;
	logic [VW-1:0] rem_q, dvs_q;
	logic [QUO_W-1:0] dq_q, sx_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W:0] srem_q;
	logic [PW-1:0] ns2_q, num_q;
	logic [VW-1:0] den_q;
	logic signed [VAL_W-1:0] mean_q;
	logic [DEV_W-1:0] dev_q;
	out_t out_q;

	logic neg, n_ge1, n_ge2;
	logic signed [SW-1:0] nsum;
	logic [MW-1:0] mag;
	logic [AW-1:0] a_start;
	logic [BW-1:0] b_start;
	logic [DDW-1:0] mean_dvd, var_dvd, dvd;
	logic [VW-1:0] dvs_start;
	logic [AW-1:0] addend;
	logic [AW:0] msum;
	logic [VW:0] t, tdiff;
	logic ge;
	logic [ROOT_W+2:0] cur, trial, sdiff;
	logic sge;
	logic [PW-1:0] s1s1;
	logic [VAL_W-1:0] q;
	logic [ROOT_W:0] rnd;
	logic [ROOT_W-1:0] rhalf;
	logic [DEV_W-1:0] dev_sat;
	logic [CNTW-1:0] steps;

	assign neg = sum[SW-1];
	assign nsum = -sum;
	assign mag = neg ? MW'(nsum) : MW'(sum);
	assign n_ge1 = count != '0;
	assign n_ge2 = count > CW'(1);

	assign mean_dvd = DDW'({mag, 1'b0}) + DDW'(count);
	assign var_dvd = {num_q, 2'b00};

	always_comb begin
		a_start = sq;
		b_start = BW'(count);
		dvd = mean_dvd;
		dvs_start = VW'({count, 1'b0});
		steps = CNTW'(QUO_W);
		unique case (cmd.op) inside
			OP_MUL_NS2: begin
				steps = CNTW'(BW);
			end
			OP_MUL_S1S1: begin
				a_start = AW'(mag);
				b_start = mag;
				steps = CNTW'(BW);
			end
			OP_MUL_DEN: begin
				a_start = AW'(count);
				b_start = BW'(count - CW'(1));
				steps = CNTW'(BW);
			end
			OP_DIV_VAR: begin
				dvd = var_dvd;
				dvs_start = den_q;
			end
			OP_SQRT: begin
				steps = CNTW'(ROOT_W);
			end
			default: begin
			end
		endcase
	end

	assign addend = p_q[0] ? a_q : '0;
	assign msum = {1'b0, p_q[PMW-1:BW]} + {1'b0, addend};

	assign t = {rem_q, dq_q[QUO_W-1]};
	assign ge = t >= {1'b0, dvs_q};
	assign tdiff = t - {1'b0, dvs_q};

	assign cur = {srem_q, sx_q[QUO_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign sge = cur >= trial;
	assign sdiff = cur - trial;

	assign s1s1 = p_q[PW-1:0];
	assign q = dq_q[VAL_W-1:0];
	assign rnd = {1'b0, root_q} + (ROOT_W + 1)'(1);
	assign rhalf = rnd[ROOT_W:1];
	assign dev_sat = (rhalf > ROOT_W'(DEV_MAX)) ? DEV_MAX : rhalf[DEV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= OP_DIV_MEAN;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				cnt_q <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			unique case (cmd.op) inside
				OP_MUL_NS2, OP_MUL_S1S1, OP_MUL_DEN: begin
					a_q <= a_start;
					p_q <= PMW'(b_start);
				end
				OP_DIV_MEAN, OP_DIV_VAR: begin
					rem_q <= VW'(dvd >> QUO_W);
					dq_q <= dvd[QUO_W-1:0];
					dvs_q <= dvs_start;
				end
				OP_SQRT: begin
					sx_q <= dq_q;
					root_q <= '0;
					srem_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q) inside
				OP_MUL_NS2, OP_MUL_S1S1, OP_MUL_DEN: begin
					p_q <= {msum, p_q[BW-1:1]};
				end
				OP_DIV_MEAN, OP_DIV_VAR: begin
					rem_q <= ge ? tdiff[VW-1:0] : t[VW-1:0];
					dq_q <= {dq_q[QUO_W-2:0], ge};
				end
				OP_SQRT: begin
					srem_q <= sge ? sdiff[ROOT_W:0] : cur[ROOT_W:0];
					root_q <= {root_q[ROOT_W-2:0], sge};
					sx_q <= {sx_q[QUO_W-3:0], 2'b00};
				end
				default: begin
				end
			endcase
		end
		if (done_q) begin
			unique case (op_q)
				OP_MUL_NS2: ns2_q <= s1s1;
				OP_MUL_S1S1: num_q <= (ns2_q > s1s1) ? ns2_q - s1s1 : '0;
				OP_MUL_DEN: den_q <= p_q[VW-1:0];
				OP_DIV_MEAN: mean_q <= neg ? -q : q;
				OP_SQRT: dev_q <= dev_sat;
				default: begin
				end
			endcase
		end
		if (cmd.load_out) begin
			out_q.mean_value <= n_ge1 ? mean_q : '0;
			out_q.mean_valid <= n_ge1;
			out_q.deviation_value <= n_ge2 ? dev_q : '0;
			out_q.deviation_valid <= n_ge2;
			out_q.counted_frames <= NOUT_W'(count);
		end
	end

	assign done = done_q;
	assign out_data = out_q;
endmodule

FILE: hw/rtl/mmd_ctrl.sv
// Sequencer of the block: accumulate, drain, run the arithmetic steps, emit.
// Depends on mmd_pkg.
module mmd_ctrl (
	input logic clk,
	input logic arst_n,
	input mmd_pkg::acc_stat_t stat,
	input logic done,
	input logic out_stall,
	output logic in_stall,
	output logic out_valid,
	output logic clear,
	output mmd_pkg::arith_cmd_t cmd
);
	import mmd_pkg::*;

	state_t state_q, state_d;
	logic fresh_q, out_valid_q, emit_ok, emit;

	assign emit_ok = !out_valid_q || !out_stall;
	assign emit = (state_q == S_EMIT) && emit_ok;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_ACCUM: if (stat.last_seen) state_d = S_DRAIN;
			S_DRAIN: begin
				if (stat.pipe_empty) begin
					state_d = stat.n_ge1 ? S_MEAN : S_EMIT;
				end
			end
			S_MEAN: if (done) state_d = stat.n_ge2 ? S_NS2 : S_EMIT;
			S_NS2: if (done) state_d = S_S1S1;
			S_S1S1: if (done) state_d = S_DEN;
			S_DEN: if (done) state_d = S_VAR;
			S_VAR: if (done) state_d = S_SQRT;
			S_SQRT: if (done) state_d = S_EMIT;
			S_EMIT: if (emit_ok) state_d = S_ACCUM;
			default: state_d = S_ACCUM;
		endcase
	end

	always_comb begin
		in_stall = state_q != S_ACCUM;
		cmd.start = 1'b0;
		cmd.op = OP_DIV_MEAN;
		cmd.load_out = emit;
		clear = emit;
		unique case (state_q)
			S_MEAN: begin
				cmd.start = fresh_q;
				cmd.op = OP_DIV_MEAN;
			end
			S_NS2: begin
				cmd.start = fresh_q;
				cmd.op = OP_MUL_NS2;
			end
			S_S1S1: begin
				cmd.start = fresh_q;
				cmd.op = OP_MUL_S1S1;
			end
			S_DEN: begin
				cmd.start = fresh_q;
				cmd.op = OP_MUL_DEN;
			end
			S_VAR: begin
				cmd.start = fresh_q;
				cmd.op = OP_DIV_VAR;
			end
			S_SQRT: begin
				cmd.start = fresh_q;
				cmd.op = OP_SQRT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCUM;
			fresh_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fresh_q <= state_d != state_q;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

FILE: verif/masked_mean_and_deviation_tb.sv
// Testbench for masked_mean_and_deviation: sends windows of Q10.8 dB frames and checks the
// mean, deviation and count of each window against an in-bench prediction.
// Depends on mmd_pkg and the masked_mean_and_deviation RTL.
module masked_mean_and_deviation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mmd_pkg::*;

	localparam int FRAME_CAP = DEF_MAX_FRAMES;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 250;

	class window_stats_tracker;
		logic signed [VAL_W-1:0] marker;
		logic [16:0] frame_count;
		logic signed [33:0] value_sum;
		logic [51:0] square_sum;
		out_t expected_stats[$];
		int mismatches;

		function new();
			marker = MARKER_RST;
			mismatches = 0;
			clear_window();
		endfunction

		function void clear_window();
			frame_count = '0;
			value_sum = '0;
			square_sum = '0;
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction

		function logic [DEV_W-1:0] spread_root(input logic [33:0] mag);
			logic [127:0] ns2, s1s1, num4, den, r, c, t;
			ns2 = {111'b0, frame_count} * {76'b0, square_sum};
			s1s1 = {94'b0, mag} * {94'b0, mag};
			num4 = (ns2 > s1s1) ? (ns2 - s1s1) << 2 : '0;
			den = {111'b0, frame_count} * ({111'b0, frame_count} - 128'd1);
			r = '0;
			for (int b = 17; b >= 0; b--) begin
				c = r | (128'd1 << b);
				t = 2 * c - 1;
				if (t * t * den <= num4)
					r = c;
			end
			return (r > {111'b0, DEV_MAX}) ? DEV_MAX : r[DEV_W-1:0];
		endfunction

		function out_t close_window();
			out_t res;
			logic [33:0] mag;
			logic [63:0] n64, q, q_neg;
			res = '0;
			mag = value_sum[33] ? 34'(-value_sum) : value_sum;
			n64 = {47'b0, frame_count};
			if (frame_count >= 1) begin
				q = (2 * {30'b0, mag} + n64) / (2 * n64);
				q_neg = -q;
				res.mean_value = value_sum[33] ? q_neg[VAL_W-1:0] : q[VAL_W-1:0];
				res.mean_valid = 1'b1;
			end
			if (frame_count >= 2) begin
				res.deviation_value = spread_root(mag);
				res.deviation_valid = 1'b1;
			end
			res.counted_frames = frame_count;
			return res;
		endfunction

		function void note_frame(input in_t f);
			logic signed [35:0] sq;
			if (f.sample_value != marker && frame_count < FRAME_CAP) begin
				frame_count++;
				value_sum += f.sample_value;
				sq = f.sample_value * f.sample_value;
				square_sum += 52'(sq);
			end
			if (f.last_sample) begin
				expected_stats.push_back(close_window());
				clear_window();
			end
		endfunction

		task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
			mismatches++;
			$display("mismatch in %s: got %h, want %h", what, got, want);
		endtask

		task check_stats(input out_t got);
			out_t want;
			if (expected_stats.size() == 0) begin
				flag_mismatch("unexpected result beat", 64'(got), 64'd0);
				return;
			end
			want = expected_stats.pop_front();
			if (got.mean_value !== want.mean_value)
				flag_mismatch("mean_value", 64'(got.mean_value), 64'(want.mean_value));
			if (got.mean_valid !== want.mean_valid)
				flag_mismatch("mean_valid", 64'(got.mean_valid), 64'(want.mean_valid));
			if (got.deviation_value !== want.deviation_value)
				flag_mismatch("deviation_value", 64'(got.deviation_value),
					64'(want.deviation_value));
			if (got.deviation_valid !== want.deviation_valid)
				flag_mismatch("deviation_valid", 64'(got.deviation_valid),
					64'(want.deviation_valid));
			if (got.counted_frames !== want.counted_frames)
				flag_mismatch("counted_frames", 64'(got.counted_frames),
					64'(want.counted_frames));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic signed [VAL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	window_stats_tracker board;
	logic signed [VAL_W-1:0] marker_now = MARKER_RST;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int frames_sent = 0;
	int quiet_cycles = 0;

	masked_mean_and_deviation #(
		.MAX_FRAMES(FRAME_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_stats(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[masked_mean_and_deviation] ERROR");
			$finish;
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return marker_now;
			1: return -18'sd131072;
			2: return 18'sd131071;
			3, 4: return 18'($urandom_range(511)) - 18'sd256;
			default: return 18'($urandom);
		endcase
	endfunction

	task automatic send_frame(input logic signed [VAL_W-1:0] value, input logic last);
		in_t f;
		f.sample_value = value;
		f.last_sample = last;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		do @(posedge clk); while (in_stall);
		board.note_frame(f);
		frames_sent++;
	endtask

	task automatic send_window(input int len);
		for (int i = 0; i < len; i++)
			send_frame(pick_value(), i == len - 1);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_marker(input logic signed [VAL_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		board.marker = value;
		marker_now = value;
	endtask

	task automatic run_windows(input int frames, input int send_pct, input int recv_pct);
		int stop_at;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		stop_at = frames_sent + frames;
		while (frames_sent < stop_at)
			send_window(($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(1, 8));
	endtask

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty window, single frame, deviation overflow, skipped marker
		send_frame(MARKER_RST, 1'b1);
		send_frame(18'sd131071, 1'b1);
		send_frame(-18'sd131072, 1'b0);
		send_frame(18'sd131071, 1'b1);
		send_frame(18'sd5, 1'b0);
		send_frame(MARKER_RST, 1'b0);
		send_frame(-18'sd5, 1'b1);
		send_frame(18'sd1, 1'b0);
		send_frame(18'sd2, 1'b1);
		send_frame(-18'sd1, 1'b0);
		send_frame(-18'sd2, 1'b1);
		send_frame(18'sd0, 1'b0);
		send_frame(18'sd0, 1'b1);
		send_frame(18'sd777, 1'b0);
		send_frame(18'sd777, 1'b1);
		send_frame(MARKER_RST, 1'b0);
		send_frame(MARKER_RST, 1'b1);

		write_marker(-18'sd131072);
		send_frame(-18'sd131072, 1'b0);
		send_frame(18'sd131071, 1'b0);
		send_frame(-18'sd131072, 1'b1);
		write_marker(18'sd131071);
		send_frame(18'sd131071, 1'b0);
		send_frame(-18'sd131072, 1'b0);
		send_frame(18'sd0, 1'b1);
		write_marker(18'sd0);
		send_frame(18'sd0, 1'b0);
		send_frame(-18'sd3, 1'b1);

		write_marker(MARKER_RST);
		run_windows(250, 0, 0);
		hold_cycles = 500;
		run_windows(80, 0, 0);
		wait_drained();
		run_windows(50, 0, 0);

		write_marker(18'($urandom));
		run_windows(360, 61, 0);
		write_marker(-18'sd131072);
		run_windows(360, 0, 61);
		write_marker(18'sd131071);
		run_windows(360, 15, 15);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[masked_mean_and_deviation] OK");
		else
			$display("[masked_mean_and_deviation] ERROR");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mmd_pkg.sv
hw/rtl/mmd_accum.sv
hw/rtl/mmd_arith.sv
hw/rtl/mmd_ctrl.sv
hw/rtl/masked_mean_and_deviation.sv
verif/masked_mean_and_deviation_tb.sv
